[rtl/core/vox_pkg.sv]
// Shared types and constants of the voxel stream parser.
`default_nettype none

package vox_pkg;

    // Parser phases, one-hot.
    typedef enum logic [8:0] {
        PH_MAGIC   = 9'b0_0000_0001,
        PH_VERSION = 9'b0_0000_0010,
        PH_MAIN    = 9'b0_0000_0100,
        PH_SCAN    = 9'b0_0000_1000,
        PH_SKIP    = 9'b0_0001_0000,
        PH_COUNT   = 9'b0_0010_0000,
        PH_VOXELS  = 9'b0_0100_0000,
        PH_DONE    = 9'b0_1000_0000,
        PH_IDLE    = 9'b1_0000_0000
    } phase_t;

    // Result status codes.
    localparam logic [2:0] ST_VOXEL   = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_MAIN    = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_MAX_COORDINATE   = 1'b1;

    localparam logic [31:0] VERSION_RESET   = 32'd150;
    localparam logic [7:0]  MAX_COORD_RESET = 8'd126;

    // Little-endian tags: "VOX ", "MAIN", "XYZI".
    localparam logic [31:0] MAGIC_WORD = 32'h2058_4F56;
    localparam logic [31:0] MAIN_WORD  = 32'h4E49_414D;
    localparam logic [31:0] XYZI_WORD  = 32'h495A_5958;

    localparam int TDATA_OUT_W = 40;

endpackage

`default_nettype wire

[rtl/core/vox_voxel_stream_parser_unit.sv]
// Top level of the voxel stream parser: header checks, tag scan and voxel output.
//
// A result is registered: it shows on m_tvalid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the parse step is one compare and a 32-bit
// decrement between the byte request and the result register.
// The input stalls only while a result waits in the output register and m_tready is low.
// Reset (aresetn low, synchronous): parser back to the magic word, output empty,
// expected_version = 150, max_coordinate = 126.
`default_nettype none

module vox_voxel_stream_parser_unit
    import vox_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [31:0]            cfg_wdata,
    // byte stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] in_byte
    input  wire logic                   s_tuser,   // [0] start_of_file
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata,   // [7:0] coord_x, [15:8] coord_y,
                                                   // [23:16] coord_z, [31:24] colour_index,
                                                   // [32] inside_domain, rest zero
    output logic [2:0]                  m_tuser    // [2:0] status
);

    // configuration registers
    logic [31:0] expected_version_reg;
    logic [7:0]  max_coord_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [23:0] asm_reg, asm_next;
    logic [1:0]  skip_reg, skip_next;
    logic [31:0] remain_reg, remain_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next, colour_reg, colour_next;
    logic        inside_reg, inside_next;
    logic        emit;

    // restart view of the state
    phase_t      cur_phase;
    logic [1:0]  cur_pos;
    logic [23:0] cur_asm;
    logic [1:0]  cur_skip;
    logic [31:0] cur_remain;
    logic [31:0] word;
    logic [31:0] remain_dec;
    logic [1:0]  skip_dec;
    logic        s_accept;

    // Input moves whenever the output slot is empty or draining this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_version_reg <= VERSION_RESET;
            max_coord_reg        <= MAX_COORD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: expected_version_reg <= cfg_wdata;
                CFG_MAX_COORDINATE:   max_coord_reg        <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // start marker restarts the parse on this very byte
        cur_phase  = s_tuser ? PH_MAGIC : phase_reg;
        cur_pos    = s_tuser ? 2'd0 : pos_reg;
        cur_asm    = s_tuser ? 24'd0 : asm_reg;
        cur_skip   = s_tuser ? 2'd0 : skip_reg;
        cur_remain = s_tuser ? 32'd0 : remain_reg;

        word       = {s_tdata, cur_asm};
        remain_dec = cur_remain - 32'd1;
        skip_dec   = cur_skip - 2'd1;

        phase_next  = cur_phase;
        pos_next    = cur_pos;
        asm_next    = cur_asm;
        skip_next   = cur_skip;
        remain_next = cur_remain;

        emit        = 1'b0;
        status_next = ST_DONE;
        x_next      = 8'd0;
        y_next      = 8'd0;
        z_next      = 8'd0;
        colour_next = 8'd0;
        inside_next = 1'b0;

        if (cur_phase == PH_IDLE) begin
            // ignore bytes until restart
        end else if (cur_phase == PH_DONE) begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            status_next = ST_DONE;
        end else if (cur_pos != 2'd3) begin
            case (cur_pos)
                2'd0:    asm_next = {cur_asm[23:8], s_tdata};
                2'd1:    asm_next = {cur_asm[23:16], s_tdata, cur_asm[7:0]};
                default: asm_next = {s_tdata, cur_asm[15:0]};
            endcase
            pos_next = cur_pos + 2'd1;
        end else begin
            // fourth byte: whole word complete
            pos_next = 2'd0;
            asm_next = 24'd0;
            case (cur_phase)
                PH_MAGIC: begin
                    if (word != MAGIC_WORD) begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        status_next = ST_MAGIC;
                    end else begin
                        phase_next = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (word != expected_version_reg) begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        status_next = ST_VERSION;
                    end else begin
                        phase_next = PH_MAIN;
                    end
                end
                PH_MAIN: begin
                    if (word != MAIN_WORD) begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        status_next = ST_MAIN;
                    end else begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_SCAN: begin
                    if (word == XYZI_WORD) begin
                        phase_next = PH_SKIP;
                        skip_next  = 2'd2;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 2'd0) begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    remain_next = word;
                    if (word == 32'd0) begin
                        phase_next  = PH_IDLE;
                        emit        = 1'b1;
                        status_next = ST_DONE;
                    end else begin
                        phase_next = PH_VOXELS;
                    end
                end
                PH_VOXELS: begin
                    emit        = 1'b1;
                    status_next = ST_VOXEL;
                    x_next      = cur_asm[7:0];
                    y_next      = cur_asm[15:8];
                    z_next      = cur_asm[23:16];
                    colour_next = s_tdata;
                    inside_next = (cur_asm[7:0] <= max_coord_reg) &&
                                  (cur_asm[15:8] <= max_coord_reg) &&
                                  (cur_asm[23:16] <= max_coord_reg);
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0) begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= 2'd0;
            asm_reg    <= 24'd0;
            skip_reg   <= 2'd0;
            remain_reg <= 32'd0;
        end else if (s_accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            asm_reg    <= asm_next;
            skip_reg   <= skip_next;
            remain_reg <= remain_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            status_reg <= status_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            colour_reg <= colour_next;
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, inside_reg, colour_reg, z_reg, y_reg, x_reg};

endmodule

`default_nettype wire

[rtl/core/vox_checker.sv]
// Port-level checks of the voxel stream parser, bound to the top level.
`default_nettype none

module vox_checker
    import vox_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [TDATA_OUT_W-1:0] m_tdata,
    input wire logic [2:0]             m_tuser
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a pending stalled result blocks the byte input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output is full");

    // status results carry an empty payload
    a_status_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_VOXEL |-> m_tdata == '0)
        else $error("non-voxel result with payload");

    // status within the defined codes, padding zero
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_MAIN && m_tdata[TDATA_OUT_W-1:33] == '0)
        else $error("bad status or padding");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind vox_voxel_stream_parser_unit vox_checker u_vox_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/vox_stream_checker.sv]
// Checker for the voxel stream parser: predicts results from byte requests and compares them.
`timescale 1ns / 100ps

module vox_stream_checker
    import vox_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [31:0]            cfg_wdata,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [TDATA_OUT_W-1:0] m_tdata,
    input  wire logic [2:0]             m_tuser,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [7:0] colour;
        logic       in_domain;
    } parse_result_t;

    parse_result_t predicted_results[$];

    // register copies
    logic [31:0] version_reg;
    logic [7:0]  max_coord_reg;

    // parser state copy
    phase_t      phase;
    logic [1:0]  byte_pos;
    logic [23:0] word_acc;
    logic [1:0]  skip_left;
    logic [31:0] voxels_left;

    int printed;

    task automatic clear_parse();
        phase       = PH_MAGIC;
        byte_pos    = '0;
        word_acc    = '0;
        skip_left   = '0;
        voxels_left = '0;
    endtask

    task automatic push_status(input logic [2:0] st);
        parse_result_t r;
        r        = '0;
        r.status = st;
        predicted_results.push_back(r);
    endtask

    task automatic header_error(input logic [2:0] st);
        phase = PH_IDLE;
        push_status(st);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sof);
        logic [31:0]   word;
        parse_result_t r;
        if (sof) clear_parse();
        if (phase == PH_IDLE) return;
        if (phase == PH_DONE) begin
            phase = PH_IDLE;
            push_status(ST_DONE);
            return;
        end
        if (byte_pos != 2'd3) begin
            word_acc = word_acc | (24'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return;
        end
        word     = {b, word_acc};
        byte_pos = '0;
        word_acc = '0;
        case (phase)
            PH_MAGIC: begin
                if (word != MAGIC_WORD) header_error(ST_MAGIC);
                else phase = PH_VERSION;
            end
            PH_VERSION: begin
                if (word != version_reg) header_error(ST_VERSION);
                else phase = PH_MAIN;
            end
            PH_MAIN: begin
                if (word != MAIN_WORD) header_error(ST_MAIN);
                else phase = PH_SCAN;
            end
            PH_SCAN: begin
                if (word == XYZI_WORD) begin
                    phase     = PH_SKIP;
                    skip_left = 2'd2;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == 2'd0) phase = PH_COUNT;
            end
            PH_COUNT: begin
                voxels_left = word;
                if (word == 32'd0) begin
                    phase = PH_IDLE;
                    push_status(ST_DONE);
                end else begin
                    phase = PH_VOXELS;
                end
            end
            PH_VOXELS: begin
                r.status    = ST_VOXEL;
                r.x         = word[7:0];
                r.y         = word[15:8];
                r.z         = word[23:16];
                r.colour    = b;
                r.in_domain = (r.x <= max_coord_reg) && (r.y <= max_coord_reg)
                              && (r.z <= max_coord_reg);
                predicted_results.push_back(r);
                voxels_left = voxels_left - 32'd1;
                if (voxels_left == 32'd0) phase = PH_DONE;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        fail_count++;
        if (printed < 40) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            printed++;
        end
    endtask

    task automatic check_result();
        parse_result_t e;
        if (predicted_results.size() == 0) begin
            report_mismatch("result with nothing predicted", {m_tuser, m_tdata[36:0]}, '0);
            return;
        end
        e = predicted_results.pop_front();
        if (m_tuser != e.status)
            report_mismatch("status", 40'(m_tuser), 40'(e.status));
        if (m_tdata[7:0] != e.x)
            report_mismatch("coord_x", 40'(m_tdata[7:0]), 40'(e.x));
        if (m_tdata[15:8] != e.y)
            report_mismatch("coord_y", 40'(m_tdata[15:8]), 40'(e.y));
        if (m_tdata[23:16] != e.z)
            report_mismatch("coord_z", 40'(m_tdata[23:16]), 40'(e.z));
        if (m_tdata[31:24] != e.colour)
            report_mismatch("colour_index", 40'(m_tdata[31:24]), 40'(e.colour));
        if (m_tdata[32] != e.in_domain)
            report_mismatch("inside_domain", 40'(m_tdata[32]), 40'(e.in_domain));
        if (m_tdata[TDATA_OUT_W-1:33] != '0)
            report_mismatch("tdata padding", 40'(m_tdata[TDATA_OUT_W-1:33]), '0);
    endtask

    // Result side first: a byte accepted on this edge cannot have its result accepted on it too.
    always @(posedge aclk) begin
        if (!aresetn) begin
            version_reg   = VERSION_RESET;
            max_coord_reg = MAX_COORD_RESET;
            clear_parse();
            predicted_results.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_we) begin
                if (cfg_index == CFG_EXPECTED_VERSION) version_reg = cfg_wdata;
                else max_coord_reg = cfg_wdata[7:0];
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser);
        end
        pending <= predicted_results.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the voxel stream parser testbench: clock, reset, byte stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_top;
    import vox_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 4;       // result is registered after its byte is accepted
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int PHASE_BYTES  = 150;     // minimum random bytes per register setting

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE
    } rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [31:0]            cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    wire logic              s_tready;
    wire logic              m_tvalid;
    wire logic [TDATA_OUT_W-1:0] m_tdata;
    wire logic [2:0]        m_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;

    // what the stimulus believes the registers hold, for building good headers
    logic [31:0] cur_version = VERSION_RESET;
    logic [7:0]  cur_max     = MAX_COORD_RESET;

    logic hold_off_req    = 1'b0;
    logic hold_off_served = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    vox_voxel_stream_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    vox_stream_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("vox_voxel_stream_parser_unit regression: fail");
            $finish;
        end
    end

    // Receiver: segments of random length, each with its own stall pattern.
    // One long hold-off when asked, so the output register fills and s_tready drops.
    initial begin : receiver
        int       seg;
        rx_mode_t mode;
        forever begin
            seg  = $urandom_range(16, 160);
            mode = rx_mode_t'($urandom_range(0, 3));
            repeat (seg) begin
                @(posedge aclk);
                if (hold_off_req && !hold_off_served) begin
                    m_tready        <= 1'b0;
                    hold_off_served <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end else begin
                    case (mode)
                        RX_ALWAYS: m_tready <= 1'b1;
                        RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
                        RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                        default:   m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    // One byte request. Bursts of random length; a gap of idle cycles before each burst.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    // Start marker goes on the first byte only, if asked.
    task automatic send_stream(input logic [7:0] bytes[$], input logic mark_start);
        foreach (bytes[i]) send_byte(bytes[i], mark_start && (i == 0));
    endtask

    task automatic append_word(ref logic [7:0] f[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++) f.push_back(w[8*i +: 8]);
    endtask

    // Voxel chunk tag, chunk size, children size, count.
    task automatic append_voxel_chunk(ref logic [7:0] f[$], input logic [31:0] count);
        append_word(f, XYZI_WORD);
        append_word(f, 32'd4 + (count << 2));
        append_word(f, 32'd0);
        append_word(f, count);
    endtask

    task automatic append_voxel(ref logic [7:0] f[$], input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] z, input logic [7:0] c);
        f.push_back(x);
        f.push_back(y);
        f.push_back(z);
        f.push_back(c);
    endtask

    function automatic logic [31:0] corrupt(input logic [31:0] w);
        return w ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    endfunction

    // Coordinates cluster on the domain edge.
    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return cur_max;
            3:       return cur_max + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_EXPECTED_VERSION) cur_version = data;
        else cur_max = data[7:0];
    endtask

    // Idle the input, let every predicted result out, then allow for the pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed files with random content; some noise, broken headers,
    // missing or misaligned tags, huge counts cut short and truncated files.
    task automatic send_random_file();
        logic [7:0]  f[$];
        int          kind;
        int          voxels;
        int          tail;
        int          keep;
        logic [31:0] count;
        logic        mark;
        kind = $urandom_range(0, 99);
        mark = ($urandom_range(0, 9) != 0);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
            send_stream(f, mark);
            return;
        end
        append_word(f, (kind < 13) ? corrupt(MAGIC_WORD) : MAGIC_WORD);
        append_word(f, (kind >= 13 && kind < 18) ? corrupt(cur_version) : cur_version);
        append_word(f, (kind >= 18 && kind < 23) ? corrupt(MAIN_WORD) : MAIN_WORD);
        repeat ($urandom_range(0, 3))
            append_word(f, ($urandom_range(0, 3) == 0) ? corrupt(XYZI_WORD) : $urandom);
        if (kind < 28) begin
            // broken header, or a tag off the word grid
            if (kind >= 23) begin
                f.push_back(8'($urandom));
                append_word(f, XYZI_WORD);
            end
            repeat ($urandom_range(1, 4)) append_word(f, $urandom);
            send_stream(f, mark);
            return;
        end
        case ($urandom_range(0, 9))
            0: begin
                count  = 32'd0;
                voxels = 0;
            end
            1: begin
                count  = $urandom | 32'h0001_0000;
                voxels = $urandom_range(1, 6);
            end
            default: begin
                count  = $urandom_range(1, 8);
                voxels = count;
            end
        endcase
        append_voxel_chunk(f, count);
        repeat (voxels) append_voxel(f, pick_coord(), pick_coord(), pick_coord(), 8'($urandom));
        tail = $urandom_range(0, 9);
        if (tail < 6) begin
            repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
        end else if (tail == 6) begin
            keep = $urandom_range(1, f.size() - 1);
            while (f.size() > keep) f.delete(f.size() - 1);
        end
        send_stream(f, mark);
    endtask

    initial begin : stimulus
        logic [7:0] f[$];
        int         phase_start;
        int         files;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes before any start marker parse from reset; two voxels, done, ignored tail
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version);
        append_word(f, MAIN_WORD);
        append_voxel_chunk(f, 32'd2);
        append_voxel(f, 8'd0, 8'd0, 8'd0, 8'd0);
        append_voxel(f, 8'd126, 8'd126, 8'd126, 8'd255);
        f.push_back(8'hFF);
        f.push_back(8'h00);
        send_stream(f, 1'b0);

        // bad magic, then bytes that must be ignored
        f.delete();
        append_word(f, MAGIC_WORD ^ 32'h0000_0001);
        append_word(f, MAGIC_WORD);
        send_stream(f, 1'b1);

        // bad version
        f.delete();
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version + 32'd1);
        send_stream(f, 1'b1);

        // bad main chunk
        f.delete();
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version);
        append_word(f, MAIN_WORD ^ 32'h8000_0000);
        send_stream(f, 1'b1);

        // empty voxel list: done on the count word, rest ignored
        f.delete();
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version);
        append_word(f, MAIN_WORD);
        append_voxel_chunk(f, 32'd0);
        append_word(f, 32'hA5A5_5A5A);
        send_stream(f, 1'b1);

        // domain edges and full-scale fields; the restart right after drops the done result
        f.delete();
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version);
        append_word(f, MAIN_WORD);
        append_word(f, 32'h455A_4953);
        append_voxel_chunk(f, 32'd3);
        append_voxel(f, 8'd255, 8'd255, 8'd255, 8'd255);
        append_voxel(f, 8'd127, 8'd0, 8'd126, 8'd1);
        append_voxel(f, 8'd126, 8'd127, 8'd127, 8'd128);
        send_stream(f, 1'b1);

        // misaligned tag: scanning never finds it; the file ends mid-word
        f.delete();
        append_word(f, MAGIC_WORD);
        append_word(f, cur_version);
        append_word(f, MAIN_WORD);
        f.push_back(8'h00);
        append_word(f, XYZI_WORD);
        append_word(f, 32'd8);
        f.push_back(8'h7E);
        send_stream(f, 1'b1);

        wait_drained();

        // Register settings: reset values, all-zero, all-ones, random.
        for (int p = 0; p < 4; p++) begin
            if (p == 1) begin
                write_reg(CFG_EXPECTED_VERSION, 32'd0);
                write_reg(CFG_MAX_COORDINATE, 32'd0);
            end else if (p == 2) begin
                write_reg(CFG_EXPECTED_VERSION, 32'hFFFF_FFFF);
                write_reg(CFG_MAX_COORDINATE, 32'd255);
            end else if (p == 3) begin
                write_reg(CFG_MAX_COORDINATE, 32'($urandom_range(1, 254)));
                write_reg(CFG_EXPECTED_VERSION, $urandom);
            end
            phase_start = bytes_sent;
            files       = 0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                // receiver hold-off lands a little way into this setting
                if (p == 2 && files == 1) hold_off_req <= 1'b1;
                send_random_file();
                files++;
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("vox_voxel_stream_parser_unit regression: pass");
        end else begin
            $display("vox_voxel_stream_parser_unit regression: fail");
        end
        $finish;
    end

endmodule
